// ===== sv/rctu_pkg.sv =====
// ----------------------------------------------------------------------------
// rctu_pkg
// Shared types and constants of the root counter timers unit: access
// commands, mode word bit positions, prescaler periods and reset values.
// ----------------------------------------------------------------------------
package rctu_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 3;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned REG_W   = 16;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned IRQ_W   = 3;

  localparam logic [REG_W-1:0] HSYNC_DIV_RESET = 16'd2146;
  localparam logic [REG_W-1:0] PERIOD_DOT      = 16'd5;
  localparam logic [REG_W-1:0] PERIOD_DIV8     = 16'd8;
  localparam logic [REG_W-1:0] PERIOD_ONE      = 16'd1;

  // clears the reached-target and overflow flags on a mode read
  localparam logic [REG_W-1:0] MODE_READ_MASK  = 16'he7ff;

  // mode word bit positions
  localparam int unsigned MODE_STOP      = 0;
  localparam int unsigned MODE_TGT_RESET = 3;
  localparam int unsigned MODE_IRQ_TGT   = 4;
  localparam int unsigned MODE_IRQ_OVF   = 5;
  localparam int unsigned MODE_IRQ_RPT   = 6;
  localparam int unsigned MODE_RATE_LO   = 8;
  localparam int unsigned MODE_RATE_HI   = 9;
  localparam int unsigned MODE_EVT       = 10;
  localparam int unsigned MODE_HIT_TGT   = 11;
  localparam int unsigned MODE_HIT_OVF   = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_RD_COUNT  = 3'd1,
    CMD_RD_MODE   = 3'd2,
    CMD_RD_TARGET = 3'd3,
    CMD_WR_COUNT  = 3'd4,
    CMD_WR_MODE   = 3'd5,
    CMD_WR_TARGET = 3'd6
  } rctu_cmd_e;

  // one item as presented to every timer in the execute stage
  typedef struct packed {
    logic             go;
    logic [CMD_W-1:0] cmd;
    logic [REG_W-1:0] wdata;
  } rctu_op_t;

endpackage

// ===== sv/rctu_timer.sv =====
// ----------------------------------------------------------------------------
// rctu_timer
// One prescaled up-counter with target compare, overflow detection, mode
// word flags and interrupt generation. Updates its state once per item.
// ----------------------------------------------------------------------------
module rctu_timer #(
  parameter int unsigned TIMER_ID   = 0,
  parameter int unsigned COUNT_BITS = rctu_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rctu_pkg::rctu_op_t           op_i,
  input  logic                         sel_i,
  input  logic [rctu_pkg::REG_W-1:0]   hsync_divisor_i,
  output logic [rctu_pkg::REG_W-1:0]   rd_data_o,
  output logic                         irq_o
);

  localparam int unsigned RW   = rctu_pkg::REG_W;
  localparam int unsigned CmpW = (COUNT_BITS > RW) ? COUNT_BITS : RW;

  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [RW-1:0]         phase_q, phase_d, phase_inc;
  logic [RW-1:0]         mode_q, mode_d;
  logic [RW-1:0]         target_q, target_d;
  logic                  heading_q, heading_d;
  logic                  fired_q, fired_d;
  logic [RW-1:0]         period;
  logic                  stopped;
  logic                  fire_ok;

  always_comb begin
    period = rctu_pkg::PERIOD_ONE;
    if (TIMER_ID == 0) begin
      if (mode_q[rctu_pkg::MODE_RATE_LO]) period = rctu_pkg::PERIOD_DOT;
    end else if (TIMER_ID == 1) begin
      if (mode_q[rctu_pkg::MODE_RATE_LO]) begin
        period = (hsync_divisor_i == '0) ? rctu_pkg::PERIOD_ONE : hsync_divisor_i;
      end
    end else if (TIMER_ID == 2) begin
      if (mode_q[rctu_pkg::MODE_RATE_HI]) period = rctu_pkg::PERIOD_DIV8;
    end
  end

  assign stopped   = (TIMER_ID == 2) && mode_q[rctu_pkg::MODE_STOP];
  assign phase_inc = phase_q + RW'(1);
  assign cnt_inc   = cnt_q + COUNT_BITS'(1);
  // one-shot unless repeat is set
  assign fire_ok   = mode_q[rctu_pkg::MODE_IRQ_RPT] || !fired_q;

  always_comb begin
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    mode_d    = mode_q;
    target_d  = target_q;
    heading_d = heading_q;
    fired_d   = fired_q;
    rd_data_o = '0;
    irq_o     = 1'b0;
    if (op_i.go) begin
      if (op_i.cmd == rctu_pkg::CMD_TICK) begin
        if (!stopped) begin
          phase_d = phase_inc;
          if (phase_inc >= period) begin
            phase_d = '0;
            cnt_d   = cnt_inc;
            if (heading_q && (CmpW'(cnt_inc) == CmpW'(target_q))) begin
              mode_d[rctu_pkg::MODE_EVT]     = 1'b1;
              mode_d[rctu_pkg::MODE_HIT_TGT] = 1'b1;
              if (mode_q[rctu_pkg::MODE_TGT_RESET]) cnt_d = '0;
              else heading_d = 1'b0;
              if (mode_q[rctu_pkg::MODE_IRQ_TGT] && fire_ok) begin
                fired_d = 1'b1;
                irq_o   = 1'b1;
              end
            end else if (cnt_inc == '0) begin
              mode_d[rctu_pkg::MODE_EVT]     = 1'b1;
              mode_d[rctu_pkg::MODE_HIT_OVF] = 1'b1;
              heading_d = (target_q != '0);
              if (mode_q[rctu_pkg::MODE_IRQ_OVF] && fire_ok) begin
                fired_d = 1'b1;
                irq_o   = 1'b1;
              end
            end
          end
        end
      end else if (sel_i) begin
        case (op_i.cmd)
          rctu_pkg::CMD_RD_COUNT: begin
            rd_data_o = RW'(cnt_q);
          end
          rctu_pkg::CMD_RD_MODE: begin
            rd_data_o = mode_q;
            mode_d    = mode_q & rctu_pkg::MODE_READ_MASK;
          end
          rctu_pkg::CMD_RD_TARGET: begin
            rd_data_o = target_q;
          end
          rctu_pkg::CMD_WR_COUNT: begin
            cnt_d     = COUNT_BITS'(op_i.wdata);
            phase_d   = '0;
            heading_d = CmpW'(COUNT_BITS'(op_i.wdata)) < CmpW'(target_q);
          end
          rctu_pkg::CMD_WR_MODE: begin
            mode_d    = op_i.wdata;
            cnt_d     = '0;
            phase_d   = '0;
            heading_d = (target_q != '0);
            fired_d   = 1'b0;
          end
          rctu_pkg::CMD_WR_TARGET: begin
            target_d  = op_i.wdata;
            phase_d   = '0;
            heading_d = CmpW'(cnt_q) < CmpW'(op_i.wdata);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      phase_q   <= '0;
      mode_q    <= '0;
      target_q  <= '0;
      heading_q <= 1'b0;
      fired_q   <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      target_q  <= target_d;
      heading_q <= heading_d;
      fired_q   <= fired_d;
    end
  end

endmodule

// ===== sv/root_counter_timers_unit.sv =====
// ----------------------------------------------------------------------------
// root_counter_timers_unit
// Prescaled root counter timers driven by a stream of clock ticks and
// register accesses, one result per item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while not stalled and returns one result per
// item, in order. An item waits in the input register, where all timers update
// their state from it in a single combinational pass, and the result is then
// held in the output register. The single state update stage sets the rate of
// one item per cycle while the output does not stall. The input register keeps
// accepting while a result waits on a stalled output as long as it is empty.
// hsync_divisor is written through cfg_we_i / cfg_wdata_i and is used from the
// next item on; a divisor of zero acts as one.
module root_counter_timers_unit #(
  parameter int unsigned NUM_TIMERS = rctu_pkg::NUM_TIMERS_DEF,
  parameter int unsigned COUNT_BITS = rctu_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rctu_pkg::REG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rctu_pkg::CMD_W-1:0]  command_i,
  input  logic [rctu_pkg::IDX_W-1:0]  counter_index_i,
  input  logic [rctu_pkg::REG_W-1:0]  write_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rctu_pkg::REG_W-1:0]  read_data_o,
  output logic [rctu_pkg::IRQ_W-1:0]  irq_pulses_o
);

  localparam int unsigned RW = rctu_pkg::REG_W;

  logic [RW-1:0]              div_q;
  logic                       in_valid_q;
  logic [rctu_pkg::CMD_W-1:0] cmd_q;
  logic [rctu_pkg::IDX_W-1:0] idx_q;
  logic [RW-1:0]              wdata_q;
  logic                       out_valid_q;
  logic [RW-1:0]              rd_q, rd_d;
  logic [rctu_pkg::IRQ_W-1:0] irq_q, irq_d;
  logic                       advance;
  logic                       accept;
  rctu_pkg::rctu_op_t         op;
  logic [RW-1:0]              tmr_rd  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]      tmr_irq;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign op.go    = advance;
  assign op.cmd   = cmd_q;
  assign op.wdata = wdata_q;

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_tmr
    rctu_timer #(
      .TIMER_ID   (t),
      .COUNT_BITS (COUNT_BITS)
    ) u_timer (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .op_i            (op),
      .sel_i           (32'(idx_q) == t),
      .hsync_divisor_i (div_q),
      .rd_data_o       (tmr_rd[t]),
      .irq_o           (tmr_irq[t])
    );
  end

  // only the addressed timer drives nonzero read data
  always_comb begin
    rd_d = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      rd_d = rd_d | tmr_rd[t];
    end
  end

  // pulses of timers beyond the output width are dropped
  for (genvar b = 0; b < rctu_pkg::IRQ_W; b++) begin : g_irq
    if (b < NUM_TIMERS) begin : g_on
      assign irq_d[b] = tmr_irq[b];
    end else begin : g_off
      assign irq_d[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= rctu_pkg::HSYNC_DIV_RESET;
    end else if (cfg_we_i) begin
      div_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      idx_q   <= counter_index_i;
      wdata_q <= write_data_i;
    end
    if (advance) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = rd_q;
  assign irq_pulses_o = irq_q;

  // register accesses never raise an interrupt
  a_access_no_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q != rctu_pkg::CMD_TICK) |=> (irq_pulses_o == '0))
    else $error("interrupt pulse on a register access");

  // ticks, writes and unknown commands return zero read data
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q != rctu_pkg::CMD_RD_COUNT && cmd_q != rctu_pkg::CMD_RD_MODE
     && cmd_q != rctu_pkg::CMD_RD_TARGET) |=> (read_data_o == '0))
    else $error("nonzero read data for a non-read item");

  // a held item is neither lost nor processed twice
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(cmd_q) && $stable(idx_q)))
    else $error("pending item lost while the output stalled");

  // a new result is only loaded into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !advance)
    else $error("output result overwritten while stalled");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives a stream of ticks and register accesses into the root counter timers
// unit and checks every result against a cycle-free timer model kept here.
// A directed opening is followed by randomized setup bursts (mode, target and
// count writes, then tick runs with reads) and noise items, under several
// hsync divisor settings and three sender/receiver idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [rctu_pkg::REG_W-1:0] word_t;
  typedef logic [rctu_pkg::CMD_W-1:0] cmd_t;
  typedef logic [rctu_pkg::IDX_W-1:0] idx_t;
  typedef logic [rctu_pkg::IRQ_W-1:0] irq_t;

  localparam int unsigned     TIMER_N    = rctu_pkg::NUM_TIMERS_DEF;
  localparam cmd_t            CMD_UNUSED = 3'd7;
  localparam int unsigned     PHASE_N    = 6;
  localparam int unsigned     PHASE_ITEMS = 213;

  typedef struct packed {
    cmd_t  cmd;
    idx_t  idx;
    word_t data;
  } timer_access_t;

  typedef struct packed {
    word_t rd;
    irq_t  irq;
  } timer_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  word_t            cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  cmd_t             command_i = '0;
  idx_t             counter_index_i = '0;
  word_t            write_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  word_t            read_data_o;
  irq_t             irq_pulses_o;

  root_counter_timers_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .counter_index_i(counter_index_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .irq_pulses_o   (irq_pulses_o)
  );

  always #1 clk_i = ~clk_i;

  // timer state as the block should hold it
  word_t hsync_div = rctu_pkg::HSYNC_DIV_RESET;
  word_t cnt_q   [TIMER_N];
  word_t phase_q [TIMER_N];
  word_t mode_q  [TIMER_N];
  word_t tgt_q   [TIMER_N];
  bit    toward_tgt[TIMER_N];
  bit    irq_fired [TIMER_N];

  timer_access_t access_q[$];
  timer_result_t result_due_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned queued_n = 0;
  int unsigned checked_n = 0;
  int unsigned err_n = 0;
  int unsigned div_settings_n = 0;
  int unsigned pulse_n[TIMER_N];

  function automatic word_t step_period(int t);
    if (t == 0) begin
      return mode_q[0][rctu_pkg::MODE_RATE_LO] ? rctu_pkg::PERIOD_DOT : rctu_pkg::PERIOD_ONE;
    end
    if (t == 1) begin
      if (!mode_q[1][rctu_pkg::MODE_RATE_LO]) return rctu_pkg::PERIOD_ONE;
      return (hsync_div == '0) ? rctu_pkg::PERIOD_ONE : hsync_div;
    end
    if (t == 2) begin
      return mode_q[2][rctu_pkg::MODE_RATE_HI] ? rctu_pkg::PERIOD_DIV8 : rctu_pkg::PERIOD_ONE;
    end
    return rctu_pkg::PERIOD_ONE;
  endfunction

  function automatic bit raise_irq(int t);
    if (mode_q[t][rctu_pkg::MODE_IRQ_RPT] || !irq_fired[t]) begin
      irq_fired[t] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit tick_timer(int t);
    bit pulse;
    bit wrapped;
    pulse = 1'b0;
    if (t == 2 && mode_q[2][rctu_pkg::MODE_STOP]) return 1'b0;
    phase_q[t] = phase_q[t] + word_t'(1);
    // a lowered divisor completes the period at once
    if (phase_q[t] < step_period(t)) return 1'b0;
    phase_q[t] = '0;
    cnt_q[t] = cnt_q[t] + word_t'(1);
    wrapped = (cnt_q[t] == '0);
    if (toward_tgt[t] && cnt_q[t] == tgt_q[t]) begin
      mode_q[t][rctu_pkg::MODE_EVT] = 1'b1;
      mode_q[t][rctu_pkg::MODE_HIT_TGT] = 1'b1;
      if (mode_q[t][rctu_pkg::MODE_TGT_RESET]) cnt_q[t] = '0;
      else toward_tgt[t] = 1'b0;
      if (mode_q[t][rctu_pkg::MODE_IRQ_TGT]) pulse = raise_irq(t);
    end else if (wrapped) begin
      mode_q[t][rctu_pkg::MODE_EVT] = 1'b1;
      mode_q[t][rctu_pkg::MODE_HIT_OVF] = 1'b1;
      toward_tgt[t] = (tgt_q[t] != '0);
      if (mode_q[t][rctu_pkg::MODE_IRQ_OVF]) pulse = raise_irq(t);
    end
    return pulse;
  endfunction

  function automatic void load_count(int t, word_t v);
    cnt_q[t] = v;
    phase_q[t] = '0;
    toward_tgt[t] = (cnt_q[t] < tgt_q[t]);
  endfunction

  function automatic timer_result_t predict_access(timer_access_t it);
    timer_result_t r;
    int t;
    r = '0;
    if (it.cmd == rctu_pkg::CMD_TICK) begin
      for (t = 0; t < TIMER_N; t++) begin
        if (tick_timer(t)) r.irq[t] = 1'b1;
      end
    end else if (it.idx < TIMER_N) begin
      t = int'(it.idx);
      case (it.cmd)
        rctu_pkg::CMD_RD_COUNT: r.rd = cnt_q[t];
        rctu_pkg::CMD_RD_TARGET: r.rd = tgt_q[t];
        rctu_pkg::CMD_RD_MODE: begin
          r.rd = mode_q[t];
          mode_q[t] = mode_q[t] & rctu_pkg::MODE_READ_MASK;
        end
        rctu_pkg::CMD_WR_COUNT: load_count(t, it.data);
        rctu_pkg::CMD_WR_MODE: begin
          mode_q[t] = it.data;
          load_count(t, '0);
          irq_fired[t] = 1'b0;
        end
        rctu_pkg::CMD_WR_TARGET: begin
          tgt_q[t] = it.data;
          load_count(t, cnt_q[t]);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic idx_t rand_idx();
    return idx_t'($urandom_range(3));
  endfunction

  function automatic word_t rand_word();
    return word_t'($urandom_range(16'hffff));
  endfunction

  // driver: payload holds while stalled, a new item or a gap otherwise
  always @(posedge clk_i) begin
    timer_access_t nxt;
    timer_result_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r = predict_access(timer_access_t'{cmd: command_i, idx: counter_index_i,
                                           data: write_data_i});
        for (int t = 0; t < TIMER_N; t++) pulse_n[t] += int'(r.irq[t]);
        result_due_q.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = access_q.pop_front();
          command_i <= nxt.cmd;
          counter_index_i <= nxt.idx;
          write_data_i <= nxt.data;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    timer_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (result_due_q.size() == 0) begin
          $display("%0t: result with nothing expected: read_data %h irq %b",
                   $time, read_data_o, irq_pulses_o);
          err_n++;
        end else begin
          exp_r = result_due_q.pop_front();
          checked_n++;
          if (read_data_o !== exp_r.rd) begin
            $display("%0t: read_data expected %h got %h", $time, exp_r.rd, read_data_o);
            err_n++;
          end
          if (irq_pulses_o !== exp_r.irq) begin
            $display("%0t: irq_pulses expected %b got %b", $time, exp_r.irq, irq_pulses_o);
            err_n++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_item(cmd_t cmd, idx_t idx, word_t data);
    access_q.push_back(timer_access_t'{cmd: cmd, idx: idx, data: data});
    queued_n++;
  endtask

  task automatic wait_drained();
    while (access_q.size() != 0 || in_valid_i || result_due_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_divisor(word_t v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hsync_div = v;
    div_settings_n++;
  endtask

  // setup bursts reach target hits and wraps; noise covers the rest
  task automatic queue_random(int unsigned n);
    int unsigned stop_at;
    int unsigned t;
    int unsigned runs;
    word_t m;
    word_t tg;
    stop_at = queued_n + n;
    while (queued_n < stop_at) begin
      if ($urandom_range(9) < 7) begin
        t = ($urandom_range(19) == 0) ? TIMER_N : $urandom_range(TIMER_N - 1);
        m = rand_word();
        if (t == 2 && $urandom_range(3) != 0) m[rctu_pkg::MODE_STOP] = 1'b0;
        push_item(rctu_pkg::CMD_WR_MODE, idx_t'(t), m);
        tg = ($urandom_range(3) != 0) ? word_t'($urandom_range(24, 1)) : rand_word();
        push_item(rctu_pkg::CMD_WR_TARGET, idx_t'(t), tg);
        if ($urandom_range(1)) begin
          if ($urandom_range(1)) begin
            push_item(rctu_pkg::CMD_WR_COUNT, idx_t'(t), tg - word_t'($urandom_range(6)));
          end else begin
            push_item(rctu_pkg::CMD_WR_COUNT, idx_t'(t),
                      16'hffff - word_t'($urandom_range(10)));
          end
        end
        runs = $urandom_range(40, 4);
        repeat (runs) begin
          if ($urandom_range(7) == 0)
            push_item(cmd_t'($urandom_range(rctu_pkg::CMD_RD_TARGET, rctu_pkg::CMD_RD_COUNT)),
                      rand_idx(), rand_word());
          else
            push_item(rctu_pkg::CMD_TICK, rand_idx(), rand_word());
        end
        push_item(rctu_pkg::CMD_RD_MODE, idx_t'(t), rand_word());
      end else begin
        repeat ($urandom_range(12, 1))
          push_item(cmd_t'($urandom_range(CMD_UNUSED)), rand_idx(), rand_word());
      end
    end
  endtask

  initial begin
    word_t div_plan[PHASE_N];
    div_plan = '{16'd3, 16'hffff, 16'd2, 16'd0, 16'd1, 16'd0};
    for (int t = 0; t < TIMER_N; t++) begin
      cnt_q[t] = '0;
      phase_q[t] = '0;
      mode_q[t] = '0;
      tgt_q[t] = '0;
      toward_tgt[t] = 1'b0;
      irq_fired[t] = 1'b0;
      pulse_n[t] = 0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    send_idle_pct = 17;
    recv_stall_pct = 52;

    // timer 0: restart at target with a one-shot interrupt
    push_item(rctu_pkg::CMD_WR_MODE, 2'd0, (16'd1 << rctu_pkg::MODE_TGT_RESET)
              | (16'd1 << rctu_pkg::MODE_IRQ_TGT) | (16'd1 << rctu_pkg::MODE_IRQ_OVF));
    push_item(rctu_pkg::CMD_WR_TARGET, 2'd0, 16'd2);
    repeat (4) push_item(rctu_pkg::CMD_TICK, 2'd0, 16'hffff);
    // second mode read sees the hit flags cleared
    push_item(rctu_pkg::CMD_RD_MODE, 2'd0, 16'h0000);
    push_item(rctu_pkg::CMD_RD_MODE, 2'd0, 16'h0000);
    // timer 1: wrap with repeating overflow interrupt
    push_item(rctu_pkg::CMD_WR_MODE, 2'd1,
              (16'd1 << rctu_pkg::MODE_IRQ_OVF) | (16'd1 << rctu_pkg::MODE_IRQ_RPT));
    push_item(rctu_pkg::CMD_WR_COUNT, 2'd1, 16'hfffe);
    repeat (2) push_item(rctu_pkg::CMD_TICK, 2'd3, 16'h0000);
    // timer 2 stopped keeps its written count; equal target heads to overflow
    push_item(rctu_pkg::CMD_WR_MODE, 2'd2, 16'd1 << rctu_pkg::MODE_STOP);
    push_item(rctu_pkg::CMD_WR_COUNT, 2'd2, 16'h1234);
    push_item(rctu_pkg::CMD_TICK, 2'd2, 16'h5a5a);
    push_item(rctu_pkg::CMD_RD_COUNT, 2'd2, 16'h0000);
    push_item(rctu_pkg::CMD_WR_TARGET, 2'd2, 16'h1234);
    // unknown command and an index with no timer behind it
    push_item(CMD_UNUSED, 2'd0, 16'hffff);
    push_item(rctu_pkg::CMD_RD_COUNT, idx_t'(TIMER_N), 16'h0000);
    push_item(rctu_pkg::CMD_WR_COUNT, idx_t'(TIMER_N), 16'hffff);
    push_item(rctu_pkg::CMD_RD_TARGET, 2'd2, 16'h0000);
    wait_drained();

    for (int p = 0; p < PHASE_N; p++) begin
      if (p == 2) begin
        send_idle_pct = 52;
        recv_stall_pct = 17;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (p == PHASE_N - 1) div_plan[p] = word_t'($urandom_range(300, 4));
      write_divisor(div_plan[p]);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d items under %0d divisor settings, %0d results compared",
             queued_n, div_settings_n, checked_n);
    $display("interrupt pulses per timer: %0d %0d %0d, errors %0d",
             pulse_n[0], pulse_n[1], pulse_n[2], err_n);
    if (err_n == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("timeout with %0d results still expected", result_due_q.size());
    $display("tb_top failed");
    $finish;
  end

endmodule
